// ===== src/scfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial command frame engine package
// Shared constants, codes and enum types of the frame engine.
// ----------------------------------------------------------------------------
package scfe_pkg;

  localparam int unsigned MaxPayloadDef = 32;

  localparam logic [7:0] TimeoutRst = 8'd5;
  localparam logic [7:0] AckRst     = 8'd128;
  localparam logic [7:0] NackRst    = 8'h5A;

  localparam logic [1:0] FUNC_RX    = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_RHDR  = 2'd2;
  localparam logic [1:0] FUNC_RDATA = 2'd3;

  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_CMD = 2'd1;
  localparam logic [1:0] KIND_PAY = 2'd2;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_ACK     = 2'd1;
  localparam logic [1:0] REG_NACK    = 2'd2;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_PAY,
    PH_WAIT,
    PH_HACK,
    PH_PACK
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD_HDR,
    ST_CMD_PAY,
    ST_RH_SIZE,
    ST_RH_SUM,
    ST_RSP_PAY,
    ST_RSP_SUM
  } fsm_e;

endpackage

// ===== src/scfe_ram.sv =====
// ----------------------------------------------------------------------------
// Frame engine RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module scfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/serial_command_frame_engine.sv =====
// ----------------------------------------------------------------------------
// Serial command frame engine
// Checks command frames from the link, hands good commands to the handler and
// sends the handler's response with its checksums.
// ----------------------------------------------------------------------------
// One input transfer is taken at a time. A command handover gives the acknowledge,
// the header, then one payload byte per cycle; a response header gives the
// command, the size and the checksum; a response payload gives the read of the
// first byte, one byte per cycle, then the checksum. The single output register
// gives one result per cycle while the output does not stall, and the command
// and response payload memories have a registered read. The payload memories
// need no clearing pass after reset.
module serial_command_frame_engine
  import scfe_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_i,
  input  logic [7:0]  resp_command_i,
  input  logic [5:0]  resp_size_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  value_o,
  output logic [7:0]  cmd_group_o,
  output logic [7:0]  cmd_code_o,
  output logic [5:0]  cmd_size_o,
  output logic        last_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW   = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned CNTW = (CW > 2) ? CW : 2;

  logic [7:0] timeout_q, ack_q, nack_q;

  fsm_e            state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [7:0]      idle_q, idle_d;
  logic [7:0]      hdr_q [3];
  logic [7:0]      hdr_d [3];
  logic [7:0]      sum_q, sum_d;
  logic [CW-1:0]   rlen_q, rlen_d;
  logic [CW-1:0]   widx_q, widx_d;
  logic [CW-1:0]   didx_q, didx_d;
  logic [7:0]      rcmd_q, rcmd_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] out_kind_q, out_kind_d;
  logic [7:0] out_value_q, out_value_d;
  logic [7:0] out_group_q, out_group_d;
  logic [7:0] out_code_q, out_code_d;
  logic [5:0] out_size_q, out_size_d;
  logic       out_last_q, out_last_d;
  logic       out_load;

  logic          cmd_we, cmd_re, rsp_we, rsp_re;
  logic [AW-1:0] cmd_waddr, cmd_raddr, rsp_waddr, rsp_raddr;
  logic [7:0]    cmd_rdata, rsp_rdata;

  logic            slot_free, accept, timed;
  phase_e          ph;
  logic [CNTW-1:0] cn;
  logic [CW-1:0]   cmd_len, didx_inc;
  logic [7:0]      hdr_sum;
  logic [5:0]      rsize;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_TIMEOUT: prdata = {24'd0, timeout_q};
      REG_ACK:     prdata = {24'd0, ack_q};
      REG_NACK:    prdata = {24'd0, nack_q};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
      ack_q     <= AckRst;
      nack_q    <= NackRst;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_TIMEOUT: timeout_q <= pwdata[7:0];
        REG_ACK:     ack_q     <= pwdata[7:0];
        REG_NACK:    nack_q    <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  scfe_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_cmd_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_we),
    .waddr_i (cmd_waddr),
    .wdata_i (data_i),
    .re_i    (cmd_re),
    .raddr_i (cmd_raddr),
    .rdata_o (cmd_rdata)
  );

  scfe_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_rsp_ram (
    .clk_i   (clk_i),
    .we_i    (rsp_we),
    .waddr_i (rsp_waddr),
    .wdata_i (data_i),
    .re_i    (rsp_re),
    .raddr_i (rsp_raddr),
    .rdata_o (rsp_rdata)
  );

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !slot_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd_len    = CW'(hdr_q[2]);
  assign didx_inc   = CW'(didx_q + 1'b1);
  assign hdr_sum    = hdr_q[0] + hdr_q[1] + hdr_q[2];
  assign timed      = idle_q >= timeout_q;
  assign ph         = timed ? PH_HDR : phase_q;
  assign cn         = timed ? '0 : cnt_q;
  assign rsize      = (resp_size_i > 6'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD) : resp_size_i;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    idle_d      = idle_q;
    hdr_d       = hdr_q;
    sum_d       = sum_q;
    rlen_d      = rlen_q;
    widx_d      = widx_q;
    didx_d      = didx_q;
    rcmd_d      = rcmd_q;
    out_load    = 1'b0;
    out_kind_d  = KIND_TX;
    out_value_d = 8'd0;
    out_group_d = 8'd0;
    out_code_d  = 8'd0;
    out_size_d  = 6'd0;
    out_last_d  = 1'b0;
    cmd_we      = 1'b0;
    cmd_waddr   = cn[AW-1:0];
    cmd_re      = 1'b0;
    cmd_raddr   = '0;
    rsp_we      = 1'b0;
    rsp_waddr   = widx_q[AW-1:0];
    rsp_re      = 1'b0;
    rsp_raddr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_RX: begin
              idle_d  = 8'd0;
              phase_d = ph;
              cnt_d   = cn;
              case (ph)
                PH_HDR: begin
                  if (cn < CNTW'(3)) begin
                    hdr_d[cn[1:0]] = data_i;
                    cnt_d          = CNTW'(cn + 1'b1);
                  end else begin
                    cnt_d    = '0;
                    out_load = 1'b1;
                    if (hdr_sum != data_i || hdr_q[2] > 8'(MAX_PAYLOAD)) begin
                      out_value_d = nack_q;
                      out_last_d  = 1'b1;
                    end else if (hdr_q[2] != 8'd0) begin
                      out_value_d = ack_q;
                      out_last_d  = 1'b1;
                      phase_d     = PH_PAY;
                      sum_d       = 8'd0;
                    end else begin
                      out_value_d = ack_q;
                      widx_d      = '0;
                      phase_d     = PH_WAIT;
                      state_d     = ST_CMD_HDR;
                    end
                  end
                end
                PH_PAY: begin
                  if (cn < CNTW'(cmd_len)) begin
                    cmd_we = 1'b1;
                    sum_d  = sum_q + data_i;
                    cnt_d  = CNTW'(cn + 1'b1);
                  end else begin
                    cnt_d    = '0;
                    out_load = 1'b1;
                    if (sum_q == data_i) begin
                      out_value_d = ack_q;
                      widx_d      = '0;
                      phase_d     = PH_WAIT;
                      state_d     = ST_CMD_HDR;
                    end else begin
                      out_value_d = nack_q;
                      out_last_d  = 1'b1;
                      phase_d     = PH_HDR;
                    end
                  end
                end
                PH_WAIT: ;
                PH_HACK: begin
                  if (data_i == ack_q && rlen_q != '0) begin
                    phase_d = PH_PACK;
                    rsp_re  = 1'b1;
                    didx_d  = '0;
                    sum_d   = 8'd0;
                    state_d = ST_RSP_PAY;
                  end else begin
                    cnt_d   = '0;
                    phase_d = PH_HDR;
                  end
                end
                default: begin
                  cnt_d   = '0;
                  phase_d = PH_HDR;
                end
              endcase
            end
            FUNC_TICK: begin
              if (idle_q != 8'hFF) begin
                idle_d = idle_q + 8'd1;
              end
            end
            FUNC_RHDR: begin
              if (phase_q == PH_WAIT) begin
                rlen_d      = CW'(rsize);
                rcmd_d      = resp_command_i;
                out_load    = 1'b1;
                out_value_d = resp_command_i;
                phase_d     = PH_HACK;
                state_d     = ST_RH_SIZE;
              end
            end
            default: begin
              if (widx_q < CW'(MAX_PAYLOAD)) begin
                rsp_we = 1'b1;
                widx_d = CW'(widx_q + 1'b1);
              end
            end
          endcase
        end
      end
      ST_CMD_HDR: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_kind_d  = KIND_CMD;
          out_group_d = hdr_q[0];
          out_code_d  = hdr_q[1];
          out_size_d  = hdr_q[2][5:0];
          if (cmd_len == '0) begin
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            cmd_re  = 1'b1;
            didx_d  = '0;
            state_d = ST_CMD_PAY;
          end
        end
      end
      ST_CMD_PAY: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_kind_d  = KIND_PAY;
          out_value_d = cmd_rdata;
          if (didx_inc == cmd_len) begin
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            cmd_re    = 1'b1;
            cmd_raddr = didx_inc[AW-1:0];
            didx_d    = didx_inc;
          end
        end
      end
      ST_RH_SIZE: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_value_d = 8'(rlen_q);
          state_d     = ST_RH_SUM;
        end
      end
      ST_RH_SUM: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_value_d = rcmd_q + 8'(rlen_q);
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_RSP_PAY: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_value_d = rsp_rdata;
          sum_d       = sum_q + rsp_rdata;
          if (didx_inc == rlen_q) begin
            state_d = ST_RSP_SUM;
          end else begin
            rsp_re    = 1'b1;
            rsp_raddr = didx_inc[AW-1:0];
            didx_d    = didx_inc;
          end
        end
      end
      ST_RSP_SUM: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_value_d = sum_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_HDR;
      cnt_q       <= '0;
      idle_q      <= 8'd0;
      rlen_q      <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      idle_q      <= idle_d;
      rlen_q      <= rlen_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q  <= hdr_d;
    sum_q  <= sum_d;
    didx_q <= didx_d;
    rcmd_q <= rcmd_d;
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_value_q <= out_value_d;
      out_group_q <= out_group_d;
      out_code_q  <= out_code_d;
      out_size_q  <= out_size_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign value_o     = out_value_q;
  assign cmd_group_o = out_group_q;
  assign cmd_code_o  = out_code_q;
  assign cmd_size_o  = out_size_q;
  assign last_o      = out_last_q;

`ifndef ASSERT_OFF
  a_more_results_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !out_last_d) |=> (state_q != ST_IDLE))
    else $error("result without last flag left the engine idle");

  a_pay_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (8'(cnt_q) <= hdr_q[2]))
    else $error("payload count beyond header size");

  a_rsp_index_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    widx_q <= CW'(MAX_PAYLOAD))
    else $error("response write index beyond maximum payload");

  a_dump_index_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMD_PAY) |-> (didx_q < cmd_len))
    else $error("command dump index beyond command size");

  a_rhdr_taken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_RHDR && phase_q == PH_WAIT)
      |=> (state_q == ST_RH_SIZE && phase_q == PH_HACK))
    else $error("response header not taken while waiting for the handler");
`endif

endmodule

// ===== tb/sv/scfe_frame_checker.sv =====
// ----------------------------------------------------------------------------
// Serial command frame engine checker
// Watches the register port and both transfer channels of the frame engine.
// It predicts every result from its own copy of the engine state and compares
// each result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module scfe_frame_checker
  import scfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_i,
  input  logic [7:0]  resp_command_i,
  input  logic [5:0]  resp_size_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  value_i,
  input  logic [7:0]  cmd_group_i,
  input  logic [7:0]  cmd_code_i,
  input  logic [5:0]  cmd_size_i,
  input  logic        last_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPay = MaxPayloadDef;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] group;
    logic [7:0] code;
    logic [5:0] size;
    logic       last;
  } engine_out_t;

  engine_out_t engine_out_q[$];
  engine_out_t step_out[$];

  logic [7:0]  timeout_ticks = TimeoutRst;
  logic [7:0]  ack_exp       = AckRst;
  logic [7:0]  nack_exp      = NackRst;
  phase_e      phase         = PH_HDR;
  int unsigned byte_count    = 0;
  logic [7:0]  idle_ticks    = '0;
  logic [7:0]  hdr     [3];
  logic [7:0]  cmd_pay [MaxPay];
  logic [7:0]  rsp_pay [MaxPay];
  int unsigned rsp_len       = 0;
  int unsigned rsp_wr        = 0;
  int          mismatches    = 0;
  int          outstanding   = 0;

  assign errors_o  = mismatches;
  assign pending_o = outstanding;

  initial begin
    foreach (hdr[i]) hdr[i] = '0;
    foreach (cmd_pay[i]) cmd_pay[i] = '0;
    foreach (rsp_pay[i]) rsp_pay[i] = '0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void add_out(input logic [1:0] kind, input logic [7:0] value,
                                  input logic [7:0] g, input logic [7:0] c,
                                  input logic [5:0] s);
    engine_out_t r;
    r.kind  = kind;
    r.value = value;
    r.group = g;
    r.code  = c;
    r.size  = s;
    r.last  = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic logic [7:0] byte_sum(input bit from_rsp, input int unsigned len);
    logic [7:0] s;
    s = '0;
    for (int unsigned i = 0; i < len && i < MaxPay; i++) begin
      s = s + (from_rsp ? rsp_pay[i] : cmd_pay[i]);
    end
    return s;
  endfunction

  function automatic void hand_over();
    add_out(KIND_TX, ack_exp, '0, '0, '0);
    add_out(KIND_CMD, '0, hdr[0], hdr[1], hdr[2][5:0]);
    for (int unsigned i = 0; i < int'(hdr[2]) && i < MaxPay; i++) begin
      add_out(KIND_PAY, cmd_pay[i], '0, '0, '0);
    end
    rsp_wr     = 0;
    byte_count = 0;
    phase      = PH_WAIT;
  endfunction

  function automatic void take_rx_byte(input logic [7:0] d);
    if (idle_ticks >= timeout_ticks) begin
      byte_count = 0;
      phase      = PH_HDR;
    end
    idle_ticks = '0;
    case (phase)
      PH_HDR: begin
        if (byte_count < 3) begin
          hdr[byte_count] = d;
          byte_count++;
        end else begin
          byte_count = 0;
          if (8'(hdr[0] + hdr[1] + hdr[2]) != d || int'(hdr[2]) > int'(MaxPay)) begin
            add_out(KIND_TX, nack_exp, '0, '0, '0);
          end else if (hdr[2] != 0) begin
            add_out(KIND_TX, ack_exp, '0, '0, '0);
            phase = PH_PAY;
          end else begin
            hand_over();
          end
        end
      end
      PH_PAY: begin
        if (byte_count < int'(hdr[2]) && byte_count < MaxPay) begin
          cmd_pay[byte_count] = d;
          byte_count++;
        end else begin
          byte_count = 0;
          if (byte_sum(1'b0, int'(hdr[2])) == d) begin
            hand_over();
          end else begin
            add_out(KIND_TX, nack_exp, '0, '0, '0);
            phase = PH_HDR;
          end
        end
      end
      PH_WAIT: ;
      PH_HACK: begin
        if (d == ack_exp && rsp_len != 0) begin
          for (int unsigned i = 0; i < rsp_len && i < MaxPay; i++) begin
            add_out(KIND_TX, rsp_pay[i], '0, '0, '0);
          end
          add_out(KIND_TX, byte_sum(1'b1, rsp_len), '0, '0, '0);
          phase = PH_PACK;
        end else begin
          byte_count = 0;
          phase      = PH_HDR;
        end
      end
      default: begin
        byte_count = 0;
        phase      = PH_HDR;
      end
    endcase
  endfunction

  function automatic void predict_engine(input logic [1:0] f, input logic [7:0] d,
                                         input logic [7:0] rc, input logic [5:0] rs);
    logic [5:0]  rsz;
    engine_out_t tail;
    step_out.delete();
    case (f)
      FUNC_RX: take_rx_byte(d);
      FUNC_TICK: begin
        if (idle_ticks != 8'hFF) idle_ticks = idle_ticks + 8'd1;
      end
      FUNC_RHDR: begin
        if (phase == PH_WAIT) begin
          rsz     = (int'(rs) > int'(MaxPay)) ? 6'(MaxPay) : rs;
          rsp_len = rsz;
          add_out(KIND_TX, rc, '0, '0, '0);
          add_out(KIND_TX, {2'b00, rsz}, '0, '0, '0);
          add_out(KIND_TX, rc + {2'b00, rsz}, '0, '0, '0);
          phase = PH_HACK;
        end
      end
      FUNC_RDATA: begin
        if (rsp_wr < MaxPay) begin
          rsp_pay[rsp_wr] = d;
          rsp_wr++;
        end
      end
      default: ;
    endcase
    if (step_out.size() != 0) begin
      tail      = step_out[step_out.size() - 1];
      tail.last = 1'b1;
      step_out[step_out.size() - 1] = tail;
    end
    foreach (step_out[i]) engine_out_q.push_back(step_out[i]);
  endfunction

  task automatic check_result();
    engine_out_t want;
    if (engine_out_q.size() == 0) begin
      report_mismatch("result with nothing predicted, value", value_i, 0);
      return;
    end
    want = engine_out_q.pop_front();
    if (kind_i !== want.kind) report_mismatch("kind", kind_i, want.kind);
    if (value_i !== want.value) report_mismatch("value", value_i, want.value);
    if (cmd_group_i !== want.group) report_mismatch("cmd_group", cmd_group_i, want.group);
    if (cmd_code_i !== want.code) report_mismatch("cmd_code", cmd_code_i, want.code);
    if (cmd_size_i !== want.size) report_mismatch("cmd_size", cmd_size_i, want.size);
    if (last_i !== want.last) report_mismatch("last", last_i, want.last);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_TIMEOUT: timeout_ticks = pwdata[7:0];
          REG_ACK:     ack_exp       = pwdata[7:0];
          REG_NACK:    nack_exp      = pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_engine(func_i, data_i, resp_command_i, resp_size_i);
      end
      if (out_valid_i && !out_stall_i) check_result();
    end
    outstanding <= engine_out_q.size();
  end

endmodule

// ===== tb/sv/tb_serial_command_frame_engine.sv =====
// ----------------------------------------------------------------------------
// Serial command frame engine testbench
// Drives command frames, timer ticks and handler responses into the engine
// under several register settings, with random idling on both channels, and
// takes the verdict from the checker that sits beside the engine.
// ----------------------------------------------------------------------------
module tb_serial_command_frame_engine;
  import scfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [7:0]  data;
  logic [7:0]  resp_command;
  logic [5:0]  resp_size;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [7:0]  value;
  logic [7:0]  cmd_group;
  logic [7:0]  cmd_code;
  logic [5:0]  cmd_size;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;

  logic [7:0]  cur_timeout = TimeoutRst;
  logic [7:0]  cur_ack     = AckRst;
  int          idle_cnt    = 0;
  int          sent        = 0;
  int          handed      = 0;
  int          writes      = 0;
  logic        quiet       = 1'b0;
  logic        hold_req    = 1'b0;

  serial_command_frame_engine uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .data_i         (data),
    .resp_command_i (resp_command),
    .resp_size_i    (resp_size),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .value_o        (value),
    .cmd_group_o    (cmd_group),
    .cmd_code_o     (cmd_code),
    .cmd_size_o     (cmd_size),
    .last_o         (last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  scfe_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .func_i         (func),
    .data_i         (data),
    .resp_command_i (resp_command),
    .resp_size_i    (resp_size),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .kind_i         (kind),
    .value_i        (value),
    .cmd_group_i    (cmd_group),
    .cmd_code_i     (cmd_code),
    .cmd_size_i     (cmd_size),
    .last_i         (last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Result side: random stall bursts in busy windows, and one long hold-off on request.
  initial begin
    int   loops;
    logic busy_rx;
    loops   = 0;
    busy_rx = 1'b1;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      loops++;
      if (loops % 64 == 0) busy_rx = ($urandom_range(0, 2) != 0);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (299) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && busy_rx && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 18)) @(negedge clk_i);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic put_item(input logic [1:0] f, input logic [7:0] d,
                          input logic [7:0] rc, input logic [5:0] rs);
    int gap;
    @(negedge clk_i);
    gap = 0;
    if (!quiet && (sent / 24) % 3 != 2 && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
    end
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid     = 1'b1;
    func         = f;
    data         = d;
    resp_command = rc;
    resp_size    = rs;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
    if (f == FUNC_RX) idle_cnt = 0;
    else if (f == FUNC_TICK && idle_cnt < 255) idle_cnt++;
  endtask

  task automatic put_tick();
    put_item(FUNC_TICK, 8'($urandom), 8'($urandom), 6'($urandom));
  endtask

  task automatic timeout_now();
    repeat (int'(cur_timeout)) put_tick();
  endtask

  // A received byte, preceded now and then by ticks that stay short of the timeout.
  task automatic send_rx(input logic [7:0] d);
    int room;
    room = int'(cur_timeout) - 1 - idle_cnt;
    if (room > 0 && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, (room < 3) ? room : 3)) put_tick();
    end
    put_item(FUNC_RX, d, 8'($urandom), 6'($urandom));
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid = 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (48) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'h0, val};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    writes++;
    if (idx == REG_TIMEOUT) cur_timeout = val;
    if (idx == REG_ACK) cur_ack = val;
  endtask

  task automatic set_regs(input logic [7:0] tmo, input logic [7:0] ack,
                          input logic [7:0] nack);
    settle();
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_ACK, ack);
    write_reg(REG_NACK, nack);
  endtask

  // One command exchange with random content, sometimes broken on purpose.
  task automatic do_frame();
    int         flaw;
    int         sz;
    int         nhdr;
    logic [7:0] grp;
    logic [7:0] cod;
    logic [7:0] chk;
    logic [7:0] psum;
    logic [7:0] pb;
    logic [7:0] ab;
    logic [5:0] rsz;
    flaw = $urandom_range(0, 19);
    grp  = 8'($urandom);
    cod  = 8'($urandom);
    sz   = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(0, 6);
    if (flaw == 1) sz = $urandom_range(33, 255);
    if (flaw == 2 && cur_timeout <= 12) begin
      nhdr = $urandom_range(1, 3);
      send_rx(8'($urandom));
      if (nhdr > 1) send_rx(8'($urandom));
      if (nhdr > 2) send_rx(8'($urandom));
      timeout_now();
    end
    chk = grp + cod + 8'(sz);
    if (flaw == 0) chk = chk ^ 8'($urandom_range(1, 255));
    send_rx(grp);
    send_rx(cod);
    send_rx(8'(sz));
    send_rx(chk);
    if (flaw <= 1) return;
    if (sz != 0) begin
      psum = '0;
      repeat (sz) begin
        pb   = 8'($urandom);
        psum = psum + pb;
        send_rx(pb);
      end
      if (flaw == 3) psum = psum ^ 8'($urandom_range(1, 255));
      send_rx(psum);
      if (flaw == 3) return;
    end
    handed++;
    if (flaw == 4 && cur_timeout <= 12) begin
      // Leave the wait through a timeout, then a header with a random checksum to realign.
      timeout_now();
      repeat (3) send_rx(8'($urandom));
      send_rx(8'($urandom));
      return;
    end
    if (flaw == 5) send_rx(8'($urandom));
    repeat ($urandom_range(0, 4)) put_item(FUNC_RDATA, 8'($urandom), 8'($urandom),
                                           6'($urandom));
    rsz = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(32, 63)) : 6'($urandom_range(0, 6));
    put_item(FUNC_RHDR, 8'($urandom), 8'($urandom), rsz);
    ab = (flaw == 6) ? 8'($urandom) : cur_ack;
    send_rx(ab);
    if (ab == cur_ack && rsz != 0) send_rx(8'($urandom));
  endtask

  task automatic run_frames(input int count);
    int stop_at;
    stop_at = sent + count;
    while (sent < stop_at) do_frame();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    func         = FUNC_RX;
    data         = '0;
    resp_command = '0;
    resp_size    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the whole response store, two bytes past its end to check the drop.
    for (int i = 0; i < 34; i++) begin
      put_item(FUNC_RDATA, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
               8'($urandom), 6'($urandom));
    end
    put_item(FUNC_RHDR, 8'h11, 8'h22, 6'd3);
    put_item(FUNC_RX, 8'hFF, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'hFF, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'h00, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'hFE, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'h5A, 8'h00, 6'd0);
    put_item(FUNC_RHDR, 8'h00, 8'hFF, 6'd63);
    put_item(FUNC_RX, AckRst, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'h00, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'h01, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'h02, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'h03, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'h07, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'h00, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'h00, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'h21, 8'h00, 6'd0);
    put_item(FUNC_RX, 8'h21, 8'h00, 6'd0);

    settle();
    hold_req = 1'b1;
    run_frames(8);

    set_regs(8'd1, 8'h00, 8'hFF);
    run_frames(1);

    set_regs(8'd0, 8'($urandom), 8'($urandom));
    repeat (6) put_item(2'($urandom), 8'($urandom), 8'($urandom), 6'($urandom));

    set_regs(8'($urandom_range(2, 12)), 8'($urandom), 8'($urandom));
    timeout_now();
    quiet = 1'b1;
    run_frames(1);

    settle();
    $display("Run covered %0d input transfers, %0d commands handed over, %0d register writes.",
             sent, handed, writes);
    $display("Timeouts of 0, 1, 5 and random, bad checksums, oversize and a long hold-off.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/scfe_pkg.sv
src/scfe_ram.sv
src/serial_command_frame_engine.sv
tb/sv/scfe_frame_checker.sv
tb/sv/tb_serial_command_frame_engine.sv
